/* design/lbef_pkg.sv */
package lbef_pkg;

  localparam int ENTITY_BUFFER_BYTES_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_W = 5;
  localparam int NAME_N = 5;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [31:0] OPEN_STR  = "<log";
  localparam logic [47:0] CLOSE_STR = "</log>";

  localparam logic [47:0] NAME_STR [NAME_N] = '{
    {"&lt;", 16'h0000}, {"&gt;", 16'h0000}, {"&amp;", 8'h00}, "&quot;", "&apos;"};
  localparam logic [2:0] NAME_LEN [NAME_N] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6};
  localparam logic [7:0] NAME_CP [NAME_N] = '{CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS};

  typedef enum logic [1:0] {
    OP_STORE,
    OP_CP,
    OP_REPLAY,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [CNT_W-1:0] cnt;
    logic             tail;
    logic [15:0]      cp;
  } cmd_t;

  function automatic logic [7:0] open_char(input logic [1:0] p);
    logic [31:0] s;
    s = OPEN_STR << {p, 3'b000};
    return s[31:24];
  endfunction

  function automatic logic [7:0] close_char(input logic [2:0] p);
    logic [47:0] s;
    s = CLOSE_STR << {p, 3'b000};
    return s[47:40];
  endfunction

  function automatic logic [7:0] name_char(input logic [2:0] k, input logic [2:0] p);
    logic [47:0] s;
    s = NAME_STR[k] << {p, 3'b000};
    return s[47:40];
  endfunction

endpackage

/* design/lbef_if.sv */
interface lbef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lbef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

/* design/log_block_entity_filter_core.sv */
// Log block filter: passes the text between "<log ...>" and "</log>" and
// decodes character entities inside it to UTF-8.
// rx carries one input word (in_byte) per valid/ready handshake; tx carries
// one output word (out_byte, last) per handshake, with last set on the final
// word produced by an input word. Input words that produce nothing give no
// output word at all.
// Input is taken at one word per cycle while the four entry command queue
// between the parser and the emitter has room.
// Emission: the emitter takes each command from the queue while idle; a
// byte held for an entity ends there, and other commands then run.
// Within a command, UTF-8 and close-tag bytes leave at one per cycle while
// tx takes them; each byte replayed from the entity buffer is first read
// from the buffer and then loaded into the output register.
// Reset (rst, synchronous) returns the parser to outside any block, drops
// any pending entity and empties the queue and output register.
// When tx stalls the output register holds its word, the emitter waits, the
// queue fills and rx.ready falls once it is full.
module log_block_entity_filter_core #(
  parameter int ENTITY_BUFFER_BYTES = lbef_pkg::ENTITY_BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lbef_in_if.sink    rx,
  lbef_out_if.source tx
);
  import lbef_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t wcmd;
  cmd_t rcmd;

  lbef_front #(
    .ENTITY_BUFFER_BYTES(ENTITY_BUFFER_BYTES)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .full (full),
    .push (push),
    .cmd  (wcmd)
  );

  lbef_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wcmd),
    .full  (full),
    .pop   (pop),
    .rdata (rcmd),
    .empty (empty)
  );

  lbef_back #(
    .ENTITY_BUFFER_BYTES(ENTITY_BUFFER_BYTES)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (rcmd),
    .pop   (pop),
    .tx    (tx)
  );

endmodule

/* design/lbef_queue.sv */
module lbef_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lbef_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output lbef_pkg::cmd_t rdata,
  output logic           empty
);
  import lbef_pkg::*;

  localparam int PTRW = $clog2(QUEUE_DEPTH);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [PTRW:0]   count;

  assign full  = (count == (PTRW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/lbef_front.sv */
module lbef_front #(
  parameter int ENTITY_BUFFER_BYTES = lbef_pkg::ENTITY_BUFFER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  lbef_in_if.sink        rx,
  input  logic           full,
  output logic           push,
  output lbef_pkg::cmd_t cmd
);
  import lbef_pkg::*;

  localparam int CAP  = ENTITY_BUFFER_BYTES - 1;
  localparam int LENW = $clog2(CAP + 1);

  localparam logic [2:0] MODE_OUT   = 3'd0;
  localparam logic [2:0] MODE_OPEN  = 3'd1;
  localparam logic [2:0] MODE_TAG   = 3'd2;
  localparam logic [2:0] MODE_BODY  = 3'd3;
  localparam logic [2:0] MODE_CLOSE = 3'd4;

  logic [2:0]      mode, mode_next;
  logic [2:0]      tmc, tmc_next;
  logic [LENW-1:0] elen, elen_next;

  logic [NAME_N-1:0] nm, nm_step;
  logic              is_num;
  logic              hex;
  logic              done;
  logic [16:0]       acc;

  logic        take;
  logic [7:0]  c;
  logic        trk_start;
  logic        trk_step;
  logic        dok;
  logic [3:0]  dval;
  logic [20:0] acc_mul;
  logic [20:0] acc_sum;
  logic [16:0] acc_sat;
  logic        hit;
  logic [7:0]  hit_cp;
  logic        is_space;

  assign rx.ready = !full;
  assign take     = rx.valid && !full;
  assign c        = rx.in_byte;
  assign is_space = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);

  always_comb begin
    dok  = 1'b0;
    dval = '0;
    if (c >= "0" && c <= "9") begin
      dok  = 1'b1;
      dval = 4'(c - "0");
    end else if (hex && c >= "a" && c <= "f") begin
      dok  = 1'b1;
      dval = 4'(c - 8'h57);
    end else if (hex && c >= "A" && c <= "F") begin
      dok  = 1'b1;
      dval = 4'(c - 8'h37);
    end
    acc_mul = hex ? {acc, 4'b0000} : ({1'b0, acc, 3'b000} + {3'b000, acc, 1'b0});
    acc_sum = acc_mul + {17'b0, dval};
    acc_sat = (acc_sum >= 21'h10000) ? 17'h10000 : acc_sum[16:0];
  end

  always_comb begin
    hit    = 1'b0;
    hit_cp = '0;
    for (int k = 0; k < NAME_N; k++) begin
      nm_step[k] = nm[k] && (elen < LENW'(NAME_LEN[k]))
                   && (c == name_char(3'(k), elen[2:0]));
      if (nm[k] && elen == LENW'(NAME_LEN[k] - 3'd1)) begin
        hit    = 1'b1;
        hit_cp = NAME_CP[k];
      end
    end
  end

  always_comb begin
    mode_next = mode;
    tmc_next  = tmc;
    elen_next = elen;
    trk_start = 1'b0;
    trk_step  = 1'b0;
    push      = 1'b0;
    cmd       = '{op: OP_REPLAY, data: c, cnt: '0, tail: 1'b1, cp: '0};
    if (take) begin
      unique case (mode)
        MODE_OPEN: begin
          if (tmc < 3'd4 && c == open_char(tmc[1:0])) begin
            tmc_next = tmc + 3'd1;
            if (tmc == 3'd3) begin
              mode_next = MODE_TAG;
            end
          end else begin
            mode_next = (c == CH_LT) ? MODE_OPEN : MODE_OUT;
            tmc_next  = (c == CH_LT) ? 3'd1 : 3'd0;
          end
        end
        MODE_TAG: begin
          if (tmc == 3'd4) begin
            if (c == CH_GT) begin
              mode_next = MODE_BODY;
              elen_next = '0;
            end else if (is_space) begin
              tmc_next = '0;
            end else begin
              mode_next = MODE_OUT;
              tmc_next  = '0;
            end
          end else if (c == CH_GT) begin
            mode_next = MODE_BODY;
            elen_next = '0;
          end
        end
        MODE_BODY: begin
          if (elen != '0) begin
            if (c == CH_SEMI && elen < LENW'(CAP)) begin
              elen_next = '0;
              if (hit) begin
                push     = 1'b1;
                cmd.op   = OP_CP;
                cmd.cp   = {8'h00, hit_cp};
                cmd.tail = 1'b0;
              end else if (is_num) begin
                push     = !acc[16];
                cmd.op   = OP_CP;
                cmd.cp   = acc[15:0];
                cmd.tail = 1'b0;
              end else begin
                push    = 1'b1;
                cmd.cnt = CNT_W'(elen);
              end
            end else if (elen >= LENW'(CAP)) begin
              elen_next = '0;
              push      = 1'b1;
              cmd.cnt   = CNT_W'(elen);
            end else begin
              push      = 1'b1;
              cmd.op    = OP_STORE;
              cmd.cnt   = CNT_W'(elen);
              cmd.tail  = 1'b0;
              elen_next = elen + 1'b1;
              trk_step  = 1'b1;
            end
          end else if (c == CH_AMP) begin
            push      = 1'b1;
            cmd.op    = OP_STORE;
            cmd.tail  = 1'b0;
            elen_next = LENW'(1);
            trk_start = 1'b1;
          end else if (c == CH_LT) begin
            mode_next = MODE_CLOSE;
            tmc_next  = 3'd1;
          end else begin
            push = 1'b1;
          end
        end
        MODE_CLOSE: begin
          if (tmc < 3'd6 && c == close_char(tmc)) begin
            tmc_next = tmc + 3'd1;
            if (tmc == 3'd5) begin
              mode_next = MODE_OUT;
              tmc_next  = '0;
              elen_next = '0;
            end
          end else begin
            push      = 1'b1;
            cmd.op    = OP_CLOSE;
            cmd.cnt   = CNT_W'(tmc);
            cmd.tail  = (c != CH_LT);
            mode_next = (c == CH_LT) ? MODE_CLOSE : MODE_BODY;
            tmc_next  = (c == CH_LT) ? 3'd1 : 3'd0;
          end
        end
        default: begin
          mode_next = (c == CH_LT) ? MODE_OPEN : MODE_OUT;
          if (c == CH_LT) begin
            tmc_next = 3'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OUT;
      tmc  <= '0;
      elen <= '0;
    end else begin
      mode <= mode_next;
      tmc  <= tmc_next;
      elen <= elen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (trk_start) begin
      nm     <= '1;
      is_num <= 1'b0;
      hex    <= 1'b0;
      done   <= 1'b0;
      acc    <= '0;
    end else if (trk_step) begin
      nm <= nm_step;
      if (elen == LENW'(1)) begin
        is_num <= (c == CH_HASH);
      end else if (elen == LENW'(2) && (c == "x" || c == "X")) begin
        hex <= 1'b1;
      end else if (!done) begin
        if (dok) begin
          acc <= acc_sat;
        end else begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/lbef_back.sv */
module lbef_back #(
  parameter int ENTITY_BUFFER_BYTES = lbef_pkg::ENTITY_BUFFER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  lbef_pkg::cmd_t head,
  output logic           pop,
  lbef_out_if.source     tx
);
  import lbef_pkg::*;

  localparam int CAP  = ENTITY_BUFFER_BYTES - 1;
  localparam int POSW = $clog2(CAP + 1);
  localparam int IDXW = $clog2(CAP);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic [7:0] mem [CAP];
  logic [7:0] mem_q;

  logic            state;
  cmd_t            cmd;
  logic [POSW-1:0] pos;
  logic            phase;

  logic            out_valid;
  logic [7:0]      out_byte;
  logic            out_last;

  logic            slot_free;
  logic [1:0]      ncp;
  logic [POSW-1:0] body_cnt;
  logic            in_body;
  logic [7:0]      utf8_byte;
  logic [7:0]      body_byte;
  logic            load;
  logic [7:0]      load_byte;
  logic            load_last;

  assign tx.valid    = out_valid;
  assign tx.out_byte = out_byte;
  assign tx.last     = out_last;
  assign slot_free   = !out_valid || tx.ready;
  assign pop         = (state == S_IDLE) && !empty;

  always_comb begin
    if (cmd.cp < 16'h0080) begin
      ncp = 2'd1;
    end else if (cmd.cp < 16'h0800) begin
      ncp = 2'd2;
    end else begin
      ncp = 2'd3;
    end
    body_cnt = (cmd.op == OP_CP) ? POSW'(ncp) : POSW'(cmd.cnt);
    in_body  = pos < body_cnt;

    utf8_byte = cmd.cp[7:0];
    unique case (ncp)
      2'd2: begin
        utf8_byte = (pos == '0) ? {3'b110, cmd.cp[10:6]} : {2'b10, cmd.cp[5:0]};
      end
      2'd3: begin
        if (pos == '0) begin
          utf8_byte = {4'b1110, cmd.cp[15:12]};
        end else if (pos == POSW'(1)) begin
          utf8_byte = {2'b10, cmd.cp[11:6]};
        end else begin
          utf8_byte = {2'b10, cmd.cp[5:0]};
        end
      end
      default: utf8_byte = cmd.cp[7:0];
    endcase

    unique case (cmd.op)
      OP_REPLAY: body_byte = mem_q;
      OP_CP:     body_byte = utf8_byte;
      OP_CLOSE:  body_byte = close_char(pos[2:0]);
      default:   body_byte = cmd.data;
    endcase

    load      = 1'b0;
    load_byte = cmd.data;
    load_last = 1'b1;
    if (state == S_RUN && slot_free) begin
      if (in_body) begin
        if (cmd.op != OP_REPLAY || phase) begin
          load      = 1'b1;
          load_byte = body_byte;
          load_last = (pos == body_cnt - 1'b1) && !cmd.tail;
        end
      end else begin
        load = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[pos[IDXW-1:0]];
    if (pop && head.op == OP_STORE) begin
      mem[head.cnt[IDXW-1:0]] <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (load) begin
      out_byte <= load_byte;
      out_last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && head.op != OP_STORE) begin
            state <= S_RUN;
            pos   <= '0;
            phase <= 1'b0;
          end
        end
        default: begin
          if (in_body && cmd.op == OP_REPLAY && !phase) begin
            phase <= 1'b1;
          end else if (load) begin
            pos   <= pos + 1'b1;
            phase <= 1'b0;
            if (load_last) begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

/* design/lbef_checker.sv */
module lbef_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_out_byte,
  input logic       tx_last
);

  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_byte) && $stable(tx_last))
    else $error("tx word changed while stalled");

  a_reset_clear: assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("tx valid after reset");

  a_open_delay: assert property (@(posedge clk) rst |-> ##6 !tx_valid)
    else $error("output before a log block could open");

  a_rx_ready_known: assert property (@(posedge clk) disable iff (rst)
    rx_valid |-> !$isunknown(rx_ready))
    else $error("rx ready unknown");

endmodule

bind log_block_entity_filter_core lbef_checker u_lbef_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_valid    (rx.valid),
  .rx_ready    (rx.ready),
  .tx_valid    (tx.valid),
  .tx_ready    (tx.ready),
  .tx_out_byte (tx.out_byte),
  .tx_last     (tx.last)
);

/* test/tb_log_block_entity_filter_core.sv */
`timescale 1ns / 1ps

module tb_log_block_entity_filter_core;
  import lbef_pkg::*;

  localparam int ENT_CAP = ENTITY_BUFFER_BYTES_DEF - 1;
  localparam int CP_LIMIT = 'h10000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] OPEN_TAG [4] = '{CH_LT, "l", "o", "g"};
  localparam logic [7:0] CLOSE_TAG [6] = '{CH_LT, "/", "l", "o", "g", CH_GT};

  typedef enum logic [2:0] {
    M_OUTSIDE,
    M_OPEN,
    M_TAG,
    M_BODY,
    M_CLOSE
  } mode_t;

  typedef enum logic [1:0] {
    RDY_FREE,
    RDY_COIN,
    RDY_PERIODIC,
    RDY_STARVED
  } rdy_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  logic clk;
  logic rst;

  lbef_in_if  rx_if ();
  lbef_out_if tx_if ();

  log_block_entity_filter_core dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .tx (tx_if)
  );

  mode_t       mode;
  int unsigned match_cnt;
  int unsigned ent_len;
  logic [7:0]  ent_buf [ENT_CAP];
  logic [7:0]  step_bytes [$];
  word_t       pending_text [$];

  int        errors = 0;
  int        words_sent;
  int        cycles = 0;
  int        burst_left;
  bit        no_gaps;
  rdy_mode_t ready_mode;
  int        stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_log_block_entity_filter_core failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left <= 0) begin
      ready_mode = rdy_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (ready_mode)
      RDY_FREE:     tx_if.ready = 1'b1;
      RDY_COIN:     tx_if.ready = 1'($urandom_range(0, 1));
      RDY_PERIODIC: tx_if.ready = (stall_left % 4) != 0;
      default:      tx_if.ready = $urandom_range(0, 9) < 2;
    endcase
  end

  always @(posedge clk) begin : check_words
    word_t want;
    if (!rst && tx_if.valid && tx_if.ready) begin
      if (pending_text.size() == 0) begin
        $error("unexpected out word: out_byte %h last %b", tx_if.out_byte, tx_if.last);
        errors++;
      end else begin
        want = pending_text.pop_front();
        if (tx_if.out_byte !== want.data) begin
          $error("out_byte expected %h actual %h", want.data, tx_if.out_byte);
          errors++;
        end
        if (tx_if.last !== want.last) begin
          $error("last expected %b actual %b", want.last, tx_if.last);
          errors++;
        end
      end
    end
  end

  function automatic bit name_is(input string s);
    int i;
    bit same;
    same = (ent_len == s.len());
    for (i = 0; same && i < s.len(); i++)
      if (ent_buf[i] != s[i]) same = 1'b0;
    return same;
  endfunction

  function automatic void replay_entity();
    int i;
    for (i = 0; i < ent_len && i < ENT_CAP; i++) step_bytes.push_back(ent_buf[i]);
  endfunction

  function automatic void decode_log_byte(input logic [7:0] c);
    int cp;
    int acc;
    int base;
    int d;
    int k;
    int i;
    logic [7:0] ch;
    word_t w;
    step_bytes.delete();
    case (mode)
      M_OPEN: begin
        if (match_cnt < 4 && c == OPEN_TAG[match_cnt]) begin
          match_cnt++;
          if (match_cnt == 4) mode = M_TAG;
        end else begin
          mode = (c == CH_LT) ? M_OPEN : M_OUTSIDE;
          match_cnt = (c == CH_LT) ? 1 : 0;
        end
      end
      M_TAG: begin
        if (match_cnt == 4) begin
          if (c == CH_GT) begin
            mode = M_BODY;
            ent_len = 0;
          end else if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) begin
            match_cnt = 0;
          end else begin
            mode = M_OUTSIDE;
            match_cnt = 0;
          end
        end else if (c == CH_GT) begin
          mode = M_BODY;
          ent_len = 0;
        end
      end
      M_BODY: begin
        if (ent_len != 0) begin
          if (c == CH_SEMI && ent_len < ENT_CAP) begin
            ent_buf[ent_len] = c;
            ent_len++;
            cp = -1;
            if (name_is("&lt;")) cp = CH_LT;
            else if (name_is("&gt;")) cp = CH_GT;
            else if (name_is("&amp;")) cp = CH_AMP;
            else if (name_is("&quot;")) cp = CH_QUOT;
            else if (name_is("&apos;")) cp = CH_APOS;
            else if (ent_len >= 2 && ent_buf[0] == CH_AMP && ent_buf[1] == CH_HASH) begin
              base = 10;
              acc = 0;
              k = 2;
              if (k < ent_len && (ent_buf[k] == "x" || ent_buf[k] == "X")) begin
                base = 16;
                k++;
              end
              d = 0;
              while (k < ent_len && d >= 0) begin
                ch = ent_buf[k];
                if (ch >= "0" && ch <= "9") d = ch - 8'h30;
                else if (base == 16 && ch >= "a" && ch <= "f") d = ch - 8'h61 + 10;
                else if (base == 16 && ch >= "A" && ch <= "F") d = ch - 8'h41 + 10;
                else d = -1;
                if (d >= 0) begin
                  acc = acc * base + d;
                  if (acc >= CP_LIMIT) acc = CP_LIMIT;
                end
                k++;
              end
              cp = acc;
            end
            if (cp < 0) begin
              replay_entity();
            end else if (cp < 'h80) begin
              step_bytes.push_back(cp[7:0]);
            end else if (cp < 'h800) begin
              step_bytes.push_back(8'hC0 | cp[10:6]);
              step_bytes.push_back(8'h80 | cp[5:0]);
            end else if (cp < CP_LIMIT) begin
              step_bytes.push_back(8'hE0 | cp[15:12]);
              step_bytes.push_back(8'h80 | cp[11:6]);
              step_bytes.push_back(8'h80 | cp[5:0]);
            end
            ent_len = 0;
          end else if (ent_len >= ENT_CAP) begin
            replay_entity();
            ent_len = 0;
            step_bytes.push_back(c);
          end else begin
            ent_buf[ent_len] = c;
            ent_len++;
          end
        end else if (c == CH_AMP) begin
          ent_buf[0] = c;
          ent_len = 1;
        end else if (c == CH_LT) begin
          mode = M_CLOSE;
          match_cnt = 1;
        end else begin
          step_bytes.push_back(c);
        end
      end
      M_CLOSE: begin
        if (match_cnt < 6 && c == CLOSE_TAG[match_cnt]) begin
          match_cnt++;
          if (match_cnt == 6) begin
            mode = M_OUTSIDE;
            match_cnt = 0;
            ent_len = 0;
          end
        end else begin
          for (i = 0; i < match_cnt && i < 6; i++) step_bytes.push_back(CLOSE_TAG[i]);
          if (c == CH_LT) begin
            match_cnt = 1;
          end else begin
            mode = M_BODY;
            match_cnt = 0;
            step_bytes.push_back(c);
          end
        end
      end
      default: begin
        if (c == CH_LT) begin
          mode = M_OPEN;
          match_cnt = 1;
        end else begin
          mode = M_OUTSIDE;
        end
      end
    endcase
    for (i = 0; i < step_bytes.size(); i++) begin
      w.data = step_bytes[i];
      w.last = (i == step_bytes.size() - 1);
      pending_text.push_back(w);
    end
  endfunction

  task automatic send_word(input logic [7:0] b);
    int gap;
    if (burst_left <= 0) begin
      rx_if.valid = 1'b0;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    rx_if.valid = 1'b1;
    rx_if.in_byte = b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    decode_log_byte(b);
    words_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  task automatic test_open_tag();
    no_gaps = 1'b1;
    send_text("x<log\t>");
    send_word(8'h00);
    send_word(8'hFF);
  endtask

  task automatic test_entities();
    no_gaps = 1'b0;
    send_text("&#;");
    send_text("&#xffff;");
    send_text("&#65536;");
  endtask

  task automatic test_close_tag();
    send_text("</l<");
    send_text("/log>");
  endtask

  task automatic test_random_blocks();
    int target;
    int pieces;
    int n;
    int j;
    logic [7:0] b;
    string hex_digits;
    hex_digits = "0123456789abcdefABCDEF";
    target = words_sent + 500;
    while (words_sent < target) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) send_word(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 5))
          3: begin
            send_text("<log");
            case ($urandom_range(0, 3))
              0: send_word(CH_SP);
              1: send_word(CH_TAB);
              2: send_word(CH_CR);
              default: send_word(CH_LF);
            endcase
            n = $urandom_range(0, 6);
            repeat (n) begin
              b = 8'($urandom_range(0, 255));
              if (b == CH_GT) b = CH_QUOT;
              send_word(b);
            end
            send_word(CH_GT);
          end
          4: send_text("<lo<log>");
          5: send_text("<logx");
          default: send_text("<log>");
        endcase
        pieces = $urandom_range(1, 12);
        repeat (pieces) begin
          case ($urandom_range(0, 9))
            4: begin
              case ($urandom_range(0, 4))
                0: send_text("&lt;");
                1: send_text("&gt;");
                2: send_text("&amp;");
                3: send_text("&quot;");
                default: send_text("&apos;");
              endcase
            end
            5, 6: begin
              send_text("&#");
              j = $urandom_range(0, 2);
              if (j == 1) send_word("x");
              if (j == 2) send_word("X");
              n = $urandom_range(0, 6);
              repeat (n) begin
                if ($urandom_range(0, 7) == 0) begin
                  b = 8'($urandom_range(0, 255));
                  if (b == CH_SEMI) b = CH_SP;
                end else if (j == 0) begin
                  b = 8'h30 + 8'($urandom_range(0, 9));
                end else begin
                  b = hex_digits[$urandom_range(0, 21)];
                end
                send_word(b);
              end
              if ($urandom_range(0, 9) != 0) send_word(CH_SEMI);
            end
            7: begin
              send_word(CH_AMP);
              n = $urandom_range(1, 18);
              repeat (n) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_SEMI) b = "q";
                send_word(b);
              end
              send_word(CH_SEMI);
            end
            8: begin
              n = $urandom_range(1, 5);
              for (j = 0; j < n; j++) send_word(CLOSE_TAG[j]);
              b = 8'($urandom_range(0, 255));
              if (b == CLOSE_TAG[n]) b = CH_LT;
              send_word(b);
            end
            9: send_word(CH_SEMI);
            default: begin
              b = 8'($urandom_range(0, 255));
              if (b == CH_AMP || b == CH_LT) b = CH_SP;
              send_word(b);
            end
          endcase
        end
        if ($urandom_range(0, 7) != 0) send_text("</log>");
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.in_byte = 8'h00;
    mode = M_OUTSIDE;
    match_cnt = 0;
    ent_len = 0;
    words_sent = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_open_tag();
    test_entities();
    test_close_tag();
    test_random_blocks();
    rx_if.valid = 1'b0;

    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_text.size() == 0) begin
      $display("tb_log_block_entity_filter_core passed");
    end else begin
      $display("tb_log_block_entity_filter_core failed");
    end
    $finish;
  end

endmodule
